// ===== rtl/pfb_pkg.sv =====
// shared types and constants for the page framebuffer pixel plotter
`default_nettype none
package pfb_pkg;

  localparam int DEF_SCREEN_COLUMNS = 128;
  localparam int DEF_SCREEN_ROWS    = 64;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] NIB_HI_MASK   = 8'hF0;
  localparam logic [7:0] NIB_LO_MASK   = 8'h0F;
  localparam logic [7:0] PIXEL_BIT     = 8'h01;

  localparam logic [1:0] BYTE_PAGE   = 2'd0;
  localparam logic [1:0] BYTE_COL_HI = 2'd1;
  localparam logic [1:0] BYTE_COL_LO = 2'd2;
  localparam logic [1:0] BYTE_DATA   = 2'd3;

  typedef struct packed {
    logic [6:0] column;
    logic [5:0] top_row;
    logic       foreground_on;
    logic [7:0] column_bits;
  } in_item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] byte_value;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic clr_we;
    logic rd_en;
    logic wr_en;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pend_any;
    logic out_free;
    logic byte_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/pfb_ram.sv =====
// generic single write, single read ram with registered read data
`default_nettype none
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/pfb_ctrl.sv =====
// controller state machine for the page framebuffer pixel plotter
`default_nettype none
module pfb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pfb_pkg::sts_t sts,
  output pfb_pkg::cmd_t      cmd
);
  import pfb_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        if (sts.pend_any) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_READ;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        cmd.wr_en = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.out_free && sts.byte_last) begin
          state_nxt = S_PICK;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/pfb_datapath.sv =====
// datapath: item registers, pixel selection, frame store access and output register
`default_nettype none
module pfb_datapath #(
  parameter int SCREEN_COLUMNS = pfb_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = pfb_pkg::DEF_SCREEN_ROWS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pfb_pkg::in_item_t in_data,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output pfb_pkg::out_item_t     out_data,
  input  wire pfb_pkg::cmd_t     cmd,
  output pfb_pkg::sts_t          sts
);
  import pfb_pkg::*;

  localparam int PAGES = SCREEN_ROWS / 8;
  localparam int DEPTH = SCREEN_COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);

  logic [6:0]    col_r;
  logic [5:0]    top_r;
  logic          fg_r;
  logic [7:0]    pend_r;
  logic [2:0]    sel_k_r;
  logic [2:0]    page_r;
  logic [2:0]    bit_r;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] clr_addr_r;
  logic [1:0]    bidx_r;
  logic [7:0]    cur_r;
  logic          out_valid_r;
  out_item_t     out_r;

  logic [7:0]    plot_mask;
  logic [6:0]    mrow;
  logic          col_ok;
  logic [2:0]    sel_k;
  logic [6:0]    sel_row;
  logic [AW-1:0] sel_addr;
  logic [7:0]    rd_data;
  logic [7:0]    pix_mask;
  logic [7:0]    new_byte;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          out_free;
  out_item_t     emit_item;

  // pixels of the incoming item that land on screen
  always_comb begin
    col_ok    = ({2'b00, in_data.column} < 9'(SCREEN_COLUMNS));
    plot_mask = '0;
    mrow      = '0;
    for (int k = 0; k < 8; k++) begin
      mrow         = {1'b0, in_data.top_row} + 7'(k);
      plot_mask[k] = in_data.column_bits[k] && col_ok && (int'(mrow[6:3]) < PAGES);
    end
  end

  // lowest pending pixel
  always_comb begin
    sel_k = '0;
    for (int k = 7; k >= 0; k--) begin
      if (pend_r[k]) begin
        sel_k = 3'(k);
      end
    end
  end

  assign sel_row  = {1'b0, top_r} + {4'b0000, sel_k};
  assign sel_addr = AW'(int'(col_r) + int'(sel_row[5:3]) * SCREEN_COLUMNS);

  assign pix_mask = PIXEL_BIT << bit_r;
  assign new_byte = fg_r ? (rd_data | pix_mask) : (rd_data & ~pix_mask);

  assign ram_we    = cmd.clr_we || cmd.wr_en;
  assign ram_waddr = cmd.clr_we ? clr_addr_r : addr_r;
  assign ram_wdata = cmd.clr_we ? 8'h00 : new_byte;

  pfb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (cmd.rd_en),
    .rd_addr (sel_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_we) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (cmd.latch) begin
      pend_r <= plot_mask;
    end else if (cmd.wr_en) begin
      pend_r[sel_k_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      col_r <= in_data.column;
      top_r <= in_data.top_row;
      fg_r  <= in_data.foreground_on;
    end
    if (cmd.rd_en) begin
      sel_k_r <= sel_k;
      page_r  <= sel_row[5:3];
      bit_r   <= sel_row[2:0];
      addr_r  <= sel_addr;
    end
    if (cmd.wr_en) begin
      cur_r <= new_byte;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    emit_item             = '0;
    emit_item.last_of_run = (bidx_r == BYTE_DATA) && (pend_r == '0);
    case (bidx_r)
      BYTE_PAGE: begin
        emit_item.byte_value = CMD_PAGE_BASE + {5'b00000, page_r};
      end
      BYTE_COL_HI: begin
        emit_item.byte_value = CMD_COL_HI | (({1'b0, col_r} & NIB_HI_MASK) >> 4);
      end
      BYTE_COL_LO: begin
        emit_item.byte_value = CMD_COL_LO | ({1'b0, col_r} & NIB_LO_MASK);
      end
      BYTE_DATA: begin
        emit_item.is_data    = 1'b1;
        emit_item.byte_value = cur_r;
      end
      default: begin
        emit_item.byte_value = cur_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      bidx_r      <= BYTE_PAGE;
    end else begin
      if (cmd.wr_en) begin
        bidx_r <= BYTE_PAGE;
      end
      if (cmd.emit && out_free) begin
        out_valid_r <= 1'b1;
        bidx_r      <= bidx_r + 2'd1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && out_free) begin
      out_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.clr_last  = (clr_addr_r == AW'(DEPTH - 1));
  assign sts.pend_any  = (pend_r != '0);
  assign sts.out_free  = out_free;
  assign sts.byte_last = (bidx_r == BYTE_DATA);

endmodule
`default_nettype wire

// ===== rtl/page_framebuffer_pixel_plotter_core.sv =====
// top level of the page framebuffer pixel plotter
// an item stays busy (in_stall high) until all of its plotted pixels are written and emitted
// each pixel: one frame store read, one write, then four output transfers
// first result byte passes PICK, READ, EMIT and the output register; output stall delays it
// after reset a clearing pass writes zeros to all SCREEN_COLUMNS * (SCREEN_ROWS / 8) bytes
// of the frame store (1024 by default), one byte a cycle, while in_stall is high
`default_nettype none
module page_framebuffer_pixel_plotter_core #(
  parameter int SCREEN_COLUMNS = pfb_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = pfb_pkg::DEF_SCREEN_ROWS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pfb_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pfb_pkg::out_item_t     out_data
);
  import pfb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfb_datapath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

// ===== tb/page_framebuffer_pixel_plotter_checker.sv =====
// checker for the page framebuffer pixel plotter: frame model, byte prediction and compare
`timescale 1ns / 1ps
module page_framebuffer_pixel_plotter_checker
  import pfb_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        pending_results,
  output int        bytes_checked,
  output int        fail_count
);

  localparam int FRAME_BYTES = SCREEN_COLUMNS * (SCREEN_ROWS / 8);

  logic [7:0] frame_bytes [FRAME_BYTES];
  out_item_t  expected_bytes [$];
  out_item_t  want;

  initial begin
    pending_results = 0;
    bytes_checked   = 0;
    fail_count      = 0;
  end

  function automatic void plot_item(input in_item_t item);
    int         k;
    int         row;
    int         page;
    int         idx;
    logic [7:0] mask;
    logic [7:0] cur;
    logic [7:0] col8;
    int         first;
    out_item_t  tail;
    col8  = {1'b0, item.column};
    first = expected_bytes.size();
    for (k = 0; k < 8; k++) begin
      if (item.column_bits[k]) begin
        row = int'(item.top_row) + k;
        if (row < SCREEN_ROWS && int'(item.column) < SCREEN_COLUMNS &&
            row / 8 < SCREEN_ROWS / 8) begin
          page = row / 8;
          idx  = int'(item.column) + page * SCREEN_COLUMNS;
          mask = PIXEL_BIT << (row % 8);
          cur  = frame_bytes[idx];
          cur  = item.foreground_on ? (cur | mask) : (cur & ~mask);
          frame_bytes[idx] = cur;
          expected_bytes.push_back('{1'b0, CMD_PAGE_BASE + 8'(page), 1'b0});
          expected_bytes.push_back('{1'b0, CMD_COL_HI | ((col8 & NIB_HI_MASK) >> 4), 1'b0});
          expected_bytes.push_back('{1'b0, CMD_COL_LO | (col8 & NIB_LO_MASK), 1'b0});
          expected_bytes.push_back('{1'b1, cur, 1'b0});
        end
      end
    end
    if (expected_bytes.size() > first) begin
      tail = expected_bytes.pop_back();
      tail.last_of_run = 1'b1;
      expected_bytes.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_bytes.delete();
      frame_bytes = '{default: 8'h00};
    end else begin
      if (in_valid && !in_stall) begin
        plot_item(in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("result transfer with nothing expected: is_data %0d byte_value 0x%02h %s %0d",
                 out_data.is_data, out_data.byte_value, "last_of_run", out_data.last_of_run);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (out_data.is_data !== want.is_data) begin
            $error("is_data mismatch: expected %0d, actual %0d", want.is_data, out_data.is_data);
            fail_count++;
          end
          if (out_data.byte_value !== want.byte_value) begin
            $error("byte_value mismatch: expected 0x%02h, actual 0x%02h",
                   want.byte_value, out_data.byte_value);
            fail_count++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run mismatch: expected %0d, actual %0d",
                   want.last_of_run, out_data.last_of_run);
            fail_count++;
          end
        end
      end
    end
    pending_results = expected_bytes.size();
  end

endmodule

// ===== tb/tb_page_framebuffer_pixel_plotter_core.sv =====
// testbench top for the page framebuffer pixel plotter: stimulus, output stalls and verdict
`timescale 1ns / 1ps
module tb_page_framebuffer_pixel_plotter_core;
  import pfb_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 235;
  localparam int LONG_HOLD    = 400;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int   pending_results;
  int   bytes_checked;
  int   check_fails;
  int   items_sent    = 0;
  int   busy_items    = 0;
  int   burst_left    = 0;
  int   cycle_count   = 0;
  logic long_hold_req = 1'b0;

  page_framebuffer_pixel_plotter_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  page_framebuffer_pixel_plotter_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .pending_results(pending_results),
    .bytes_checked  (bytes_checked),
    .fail_count     (check_fails)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL page_framebuffer_pixel_plotter_core");
    $finish;
  end

  // output side stall pattern, plus one long hold on request
  initial begin : receiver
    stall_mode_t mode;
    int          mode_left;
    int          hold_left;
    out_stall = 1'b0;
    mode      = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          STALL_NONE:   out_stall <= 1'b0;
          STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
          default:      out_stall <= ~out_stall;
        endcase
      end
    end
  end

  task automatic send_item(input in_item_t item);
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
    end
  endtask

  initial begin : stimulus
    in_item_t   item;
    logic [7:0] on_screen;
    logic       hold_started;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    hold_started = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // page corners, clipped rows, empty items, set and clear on the same pixel
    send_item('{7'd0,   6'd0,  1'b1, 8'hFF});
    send_item('{7'd127, 6'd56, 1'b1, 8'hFF});
    send_item('{7'd127, 6'd63, 1'b1, 8'hFF});
    send_item('{7'd5,   6'd60, 1'b1, 8'hF0});
    send_item('{7'd5,   6'd60, 1'b1, 8'h0F});
    send_item('{7'd9,   6'd0,  1'b1, 8'h00});
    send_item('{7'd0,   6'd0,  1'b0, 8'h55});
    send_item('{7'd0,   6'd4,  1'b1, 8'hFF});
    send_item('{7'd85,  6'd42, 1'b1, 8'hAA});
    send_item('{7'd42,  6'd21, 1'b0, 8'h55});
    send_item('{7'd64,  6'd0,  1'b1, 8'h80});
    send_item('{7'd64,  6'd7,  1'b0, 8'h01});
    send_item('{7'd64,  6'd7,  1'b0, 8'h01});
    send_item('{7'd127, 6'd0,  1'b0, 8'hFF});
    send_item('{7'd100, 6'd32, 1'b1, 8'h01});
    send_item('{7'd100, 6'd32, 1'b1, 8'h01});
    send_item('{7'd15,  6'd63, 1'b0, 8'hFF});
    send_item('{7'd16,  6'd57, 1'b1, 8'hFE});
    send_item('{7'd127, 6'd0,  1'b1, 8'hFF});

    // random items, half of them on a narrow band of columns so set and clear overlap
    while (busy_items < RANDOM_ITEMS) begin
      item.column        = ($urandom_range(0, 1) == 1) ? 7'($urandom_range(60, 67))
                                                       : 7'($urandom_range(0, 127));
      item.top_row       = 6'($urandom_range(0, 63));
      item.foreground_on = 1'($urandom_range(0, 1));
      item.column_bits   = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom);
      on_screen = (item.top_row <= 56) ? 8'hFF : (8'hFF >> (item.top_row - 56));
      if (|(item.column_bits & on_screen)) busy_items++;
      if (busy_items >= 120 && !hold_started) begin
        hold_started  = 1'b1;
        long_hold_req = 1'b1;
        burst_left    = 60;
      end
      send_item(item);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (pending_results != 0) begin
      $error("%0d expected result bytes never arrived", pending_results);
    end
    $display("covered %0d items (%0d random with on-screen pixels), %0d result bytes checked",
             items_sent, busy_items, bytes_checked);
    $display("included clipped rows, empty items, set/clear overlap and one long output hold");
    if (check_fails == 0 && pending_results == 0) begin
      $display("PASS page_framebuffer_pixel_plotter_core");
    end else begin
      $display("FAIL page_framebuffer_pixel_plotter_core");
    end
    $finish;
  end

endmodule
